FILE: rtl/srq_pkg.sv
package srq_pkg;

  localparam int ID_W   = 8;
  localparam int PRIO_W = 8;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  // request codes
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic              exec;  // word accepted this cycle, load result register
    logic              enq;   // insert the incoming entry
    logic              deq;   // pop the head entry
    logic [STAT_W-1:0] code;  // status of this word
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

FILE: rtl/srq_ctrl.sv
module srq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  output logic              out_valid,
  input  logic              out_stall,
  input  srq_pkg::dp_stat_t dp_stat,
  output srq_pkg::cmd_t     cmd
);
  import srq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,  // result register empty
    ST_HOLD = 2'b10   // result register holds a word
  } state_t;

  state_t state_r, state_nxt;
  logic   exec;

  assign out_valid = (state_r == ST_HOLD);
  // a held result that is being taken frees the register for the next word
  assign in_stall  = out_valid && out_stall;
  assign exec      = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (exec) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (!exec && !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd.exec = exec;
    cmd.enq  = exec && (in_req_type == REQ_ENQ) && !dp_stat.full;
    cmd.deq  = exec && (in_req_type == REQ_DEQ) && !dp_stat.empty;
    if (in_req_type == REQ_ENQ) begin
      cmd.code = dp_stat.full ? STAT_FULL : STAT_OK;
    end else begin
      cmd.code = dp_stat.empty ? STAT_EMPTY : STAT_OK;
    end
  end

  a_exec_loads: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_valid)
    else $error("accepted word did not produce a result");

  a_stall_only_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.enq && cmd.deq))
    else $error("insert and pop in one cycle");

endmodule

FILE: rtl/srq_dp.sv
module srq_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  srq_pkg::cmd_t               cmd,
  output srq_pkg::dp_stat_t           dp_stat,
  input  logic [srq_pkg::ID_W-1:0]    in_proc_id,
  input  logic [srq_pkg::PRIO_W-1:0]  in_prio,
  output logic [srq_pkg::STAT_W-1:0]  out_status,
  output logic [srq_pkg::ID_W-1:0]    out_id,
  output logic [srq_pkg::PRIO_W-1:0]  out_prio,
  output logic [srq_pkg::OCC_W-1:0]   out_occupancy
);
  import srq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // cell array, head at index 0; contents above the count are don't-care
  logic [ID_W-1:0]   ids_r   [QUEUE_DEPTH];
  logic [PRIO_W-1:0] prios_r [QUEUE_DEPTH];
  logic [ID_W-1:0]   ids_nxt   [QUEUE_DEPTH];
  logic [PRIO_W-1:0] prios_nxt [QUEUE_DEPTH];

  wire [ID_W-1:0]   prev_id   [QUEUE_DEPTH];
  wire [PRIO_W-1:0] prev_prio [QUEUE_DEPTH];
  wire [ID_W-1:0]   next_id   [QUEUE_DEPTH];
  wire [PRIO_W-1:0] next_prio [QUEUE_DEPTH];

  wire [QUEUE_DEPTH-1:0] keep;       // cell holds an entry that outranks or ties
  wire [QUEUE_DEPTH-1:0] prev_keep;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW+OCC_W-1:0] occ_ext;

  logic [STAT_W-1:0] status_r;
  logic [ID_W-1:0]   id_r;
  logic [PRIO_W-1:0] prio_r;
  logic [OCC_W-1:0]  occ_r;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    assign keep[g] = (CW'(g) < count_r) && (prios_r[g] >= in_prio);
    if (g == 0) begin : g_head
      assign prev_id[g]   = in_proc_id;
      assign prev_prio[g] = in_prio;
    end else begin : g_body
      assign prev_id[g]   = ids_r[g-1];
      assign prev_prio[g] = prios_r[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign next_id[g]   = ids_r[g];
      assign next_prio[g] = prios_r[g];
    end else begin : g_mid
      assign next_id[g]   = ids_r[g+1];
      assign next_prio[g] = prios_r[g+1];
    end
  end

  // keep is a prefix, so the insert slot is the first cell without keep
  assign prev_keep = {keep[QUEUE_DEPTH-2:0], 1'b1};

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ids_nxt[i]   = ids_r[i];
      prios_nxt[i] = prios_r[i];
      if (cmd.enq && !keep[i]) begin
        if (prev_keep[i]) begin
          ids_nxt[i]   = in_proc_id;
          prios_nxt[i] = in_prio;
        end else begin
          ids_nxt[i]   = prev_id[i];
          prios_nxt[i] = prev_prio[i];
        end
      end else if (cmd.deq) begin
        ids_nxt[i]   = next_id[i];
        prios_nxt[i] = next_prio[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.enq)      count_nxt = count_r + 1'b1;
    else if (cmd.deq) count_nxt = count_r - 1'b1;
  end

  assign occ_ext = {{OCC_W{1'b0}}, count_nxt};

  assign dp_stat.empty = (count_r == '0);
  assign dp_stat.full  = (count_r == CW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ids_r[i]   <= ids_nxt[i];
      prios_r[i] <= prios_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= cmd.code;
      id_r     <= cmd.deq ? ids_r[0] : '0;
      prio_r   <= cmd.deq ? prios_r[0] : '0;
      occ_r    <= occ_ext[OCC_W-1:0];
    end
  end

  assign out_status    = status_r;
  assign out_id        = id_r;
  assign out_prio      = prio_r;
  assign out_occupancy = occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond depth");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deq |=> count_r == $past(count_r) - 1'b1)
    else $error("pop did not decrement count");

endmodule

FILE: rtl/sorted_priority_ready_queue.sv
// Channel  | Handshake        | Word
// ---------+------------------+-------------------------------------------------
// in_      | in_valid/in_stall   | in_req_type, in_proc_id, in_prio
// out_     | out_valid/out_stall | out_status, out_id, out_prio, out_occupancy
//
// One word per cycle: each accepted word updates the sorted cell array and
// loads the result register at the same edge; the result is offered the cycle
// after. The result register is the only limit: in_stall is high only while a
// held result is stalled. Reset (rst_n low, synchronous) empties the queue and
// the result register; no clearing pass is needed.
module sorted_priority_ready_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [srq_pkg::ID_W-1:0]    in_proc_id,
  input  logic [srq_pkg::PRIO_W-1:0]  in_prio,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [srq_pkg::STAT_W-1:0]  out_status,
  output logic [srq_pkg::ID_W-1:0]    out_id,
  output logic [srq_pkg::PRIO_W-1:0]  out_prio,
  output logic [srq_pkg::OCC_W-1:0]   out_occupancy
);
  import srq_pkg::*;

  cmd_t     cmd;      // accept, insert/pop strobes and status code
  dp_stat_t dp_stat;  // empty/full flags from the cell array

  // handshake and op decode
  srq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .dp_stat     (dp_stat),
    .cmd         (cmd)
  );

  // sorted cell array: every cell compares against the new priority at once,
  // cells behind the insert point shift down, a pop shifts everything up
  srq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .dp_stat       (dp_stat),
    .in_proc_id    (in_proc_id),
    .in_prio       (in_prio),
    .out_status    (out_status),
    .out_id        (out_id),
    .out_prio      (out_prio),
    .out_occupancy (out_occupancy)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  import srq_pkg::*;

  localparam int QDEPTH       = 16;
  localparam int RAND_PER_RUN = 510;      // random words in each phase
  localparam int SETTLE_CYC   = 10;

  // one result word as it leaves the block
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [OCC_W-1:0]  occ;
  } srq_result_t;

  localparam srq_result_t NO_RESULT = '0;

  // directed word; 'typed' marks a row whose result is written out by hand
  typedef struct {
    logic              req;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    bit                typed;
    srq_result_t       res;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_req_type;
  logic [ID_W-1:0]     in_proc_id;
  logic [PRIO_W-1:0]   in_prio;
  logic                out_valid;
  logic                out_stall;
  logic [STAT_W-1:0]   out_status;
  logic [ID_W-1:0]     out_id;
  logic [PRIO_W-1:0]   out_prio;
  logic [OCC_W-1:0]    out_occupancy;

  // shadow copy of the ready list, head at index 0
  logic [ID_W-1:0]     shadow_ids   [QDEPTH];
  logic [PRIO_W-1:0]   shadow_prios [QDEPTH];
  int                  shadow_len;

  srq_result_t         pending_results [$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int words_sent;
  int results_seen;
  int full_seen;
  int empty_seen;
  int peak_occ;

  // Directed words: empty pop, field extremes, ties at equal priority, fill
  // to the brim, an enqueue that gets dropped, then a late high-priority
  // entry jumping to the head.
  stim_row_t stim_rows [24] = '{
    '{REQ_DEQ, 8'hAA, 8'h55, 1'b1, '{STAT_EMPTY, 8'h00, 8'h00, 5'd0}},
    '{REQ_ENQ, 8'h00, 8'h00, 1'b1, '{STAT_OK,    8'h00, 8'h00, 5'd1}},
    '{REQ_ENQ, 8'hFF, 8'hFF, 1'b1, '{STAT_OK,    8'h00, 8'h00, 5'd2}},
    '{REQ_ENQ, 8'h10, 8'h80, 1'b0, NO_RESULT},
    '{REQ_ENQ, 8'h11, 8'h80, 1'b0, NO_RESULT},
    '{REQ_ENQ, 8'h12, 8'h80, 1'b0, NO_RESULT},
    '{REQ_ENQ, 8'h13, 8'h00, 1'b0, NO_RESULT},
    '{REQ_DEQ, 8'h00, 8'h00, 1'b1, '{STAT_OK,    8'hFF, 8'hFF, 5'd5}},
    '{REQ_ENQ, 8'h20, 8'h7F, 1'b0, NO_RESULT},
    '{REQ_ENQ, 8'h21, 8'h81, 1'b0, NO_RESULT},
    '{REQ_ENQ, 8'h22, 8'h80, 1'b0, NO_RESULT},
    '{REQ_ENQ, 8'h23, 8'h01, 1'b0, NO_RESULT},
    '{REQ_ENQ, 8'h24, 8'hFE, 1'b0, NO_RESULT},
    '{REQ_ENQ, 8'h25, 8'h80, 1'b0, NO_RESULT},
    '{REQ_ENQ, 8'h26, 8'h40, 1'b0, NO_RESULT},
    '{REQ_ENQ, 8'h27, 8'h00, 1'b0, NO_RESULT},
    '{REQ_ENQ, 8'h28, 8'hFF, 1'b0, NO_RESULT},
    '{REQ_ENQ, 8'h29, 8'h80, 1'b0, NO_RESULT},
    '{REQ_ENQ, 8'h2A, 8'h01, 1'b0, NO_RESULT},
    '{REQ_ENQ, 8'hFF, 8'hFF, 1'b1, '{STAT_FULL,  8'h00, 8'h00, 5'd16}},
    '{REQ_DEQ, 8'h5A, 8'hA5, 1'b0, NO_RESULT},
    '{REQ_DEQ, 8'h00, 8'h00, 1'b0, NO_RESULT},
    '{REQ_ENQ, 8'h77, 8'hFF, 1'b0, NO_RESULT},
    '{REQ_DEQ, 8'hFF, 8'hFF, 1'b0, NO_RESULT}
  };

  sorted_priority_ready_queue #(
    .QUEUE_DEPTH (QDEPTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_proc_id    (in_proc_id),
    .in_prio       (in_prio),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_id        (out_id),
    .out_prio      (out_prio),
    .out_occupancy (out_occupancy)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow ready list: a new entry goes behind every entry of equal or
  // higher priority, so ties leave first in, first out.
  function automatic srq_result_t apply_to_shadow(input logic req,
                                                  input logic [ID_W-1:0] id,
                                                  input logic [PRIO_W-1:0] prio);
    srq_result_t r;
    int          slot;
    r = NO_RESULT;
    r.status = STAT_OK;
    if (req == REQ_ENQ) begin
      if (shadow_len >= QDEPTH) begin
        r.status = STAT_FULL;
      end else begin
        slot = 0;
        while (slot < shadow_len && shadow_prios[slot] >= prio) slot++;
        for (int i = shadow_len; i > slot; i--) begin
          shadow_ids[i]   = shadow_ids[i-1];
          shadow_prios[i] = shadow_prios[i-1];
        end
        shadow_ids[slot]   = id;
        shadow_prios[slot] = prio;
        shadow_len++;
      end
    end else begin
      if (shadow_len == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.id   = shadow_ids[0];
        r.prio = shadow_prios[0];
        for (int i = 1; i < shadow_len; i++) begin
          shadow_ids[i-1]   = shadow_ids[i];
          shadow_prios[i-1] = shadow_prios[i];
        end
        shadow_len--;
      end
    end
    r.occ = shadow_len[OCC_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns  MISMATCH  %s", $time, msg);
    mismatches++;
  endtask

  // Offer one word; idle gaps are rolled at each falling edge, then the
  // word is held until the block takes it. The shadow list moves on the
  // accepting edge.
  task automatic send_word(input logic req, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] prio,
                           input bit typed, input srq_result_t typed_res);
    srq_result_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_proc_id  <= id;
    in_prio     <= prio;
    do @(posedge clk); while (in_stall);
    predicted = apply_to_shadow(req, id, prio);
    pending_results.push_back(typed ? typed_res : predicted);
    words_sent++;
  endtask

  // receiver back-pressure, rolled afresh each cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // result checker: every word taken is compared with the oldest prediction
  always @(posedge clk) begin : result_check
    srq_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_status == STAT_FULL) full_seen++;
      if (out_status == STAT_EMPTY) empty_seen++;
      if (out_occupancy > peak_occ) peak_occ = out_occupancy;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word with none pending: st=%0d id=%02h pr=%02h occ=%0d",
                                  out_status, out_id, out_prio, out_occupancy));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("word %0d status: want %0d got %0d",
                                    results_seen, want.status, out_status));
        if (out_id !== want.id)
          report_mismatch($sformatf("word %0d id: want %02h got %02h",
                                    results_seen, want.id, out_id));
        if (out_prio !== want.prio)
          report_mismatch($sformatf("word %0d prio: want %02h got %02h",
                                    results_seen, want.prio, out_prio));
        if (out_occupancy !== want.occ)
          report_mismatch($sformatf("word %0d occupancy: want %0d got %0d",
                                    results_seen, want.occ, out_occupancy));
      end
    end
  end

  initial begin
    logic              req;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    int                enq_pct;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_ENQ;
    in_proc_id    = '0;
    in_prio       = '0;
    shadow_len    = 0;
    mismatches    = 0;
    words_sent    = 0;
    results_seen  = 0;
    full_seen     = 0;
    empty_seen    = 0;
    peak_occ      = 0;
    enq_pct       = 50;
    send_idle_pct = 37;
    recv_idle_pct = 54;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i])
      send_word(stim_rows[i].req, stim_rows[i].id, stim_rows[i].prio,
                stim_rows[i].typed, stim_rows[i].res);

    // phase 0: sender 37 / receiver 54, phase 1: swapped, phase 2: no idling
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 54 : 0;
      recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 37 : 0;
      for (int n = 0; n < RAND_PER_RUN; n++) begin
        // hold off once mid-run until the result pipe has drained
        if (phase == 1 && n == RAND_PER_RUN / 2) begin
          @(negedge clk);
          in_valid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
        // swing the push/pop mix every 40 words so the list drifts between
        // empty and full rather than hovering half way
        if (n % 40 == 0) begin
          case ($urandom_range(0, 2))
            0:       enq_pct = 25;
            1:       enq_pct = 50;
            default: enq_pct = 80;
          endcase
        end
        req = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
        id  = ID_W'($urandom_range(0, 255));
        // crowd priorities into small sets to get plenty of ties
        case ($urandom_range(0, 3))
          0:       prio = PRIO_W'($urandom_range(0, 255));
          1:       prio = PRIO_W'($urandom_range(0, 3));
          2:       prio = PRIO_W'($urandom_range(252, 255));
          default: prio = PRIO_W'($urandom_range(8'h7F, 8'h81));
        endcase
        send_word(req, id, prio, 1'b0, NO_RESULT);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    $display("run covered %0d words, %0d results checked: %0d dropped as full, %0d pops on empty",
             words_sent, results_seen, full_seen, empty_seen);
    $display("peak occupancy %0d of %0d, %0d mismatches", peak_occ, QDEPTH, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("watchdog expired with %0d results outstanding", pending_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
